// ----- rtl/mmm_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mdio management master package
// shared types, constants and the frame word builder
// ---------------------------------------------------------------------------
package mmm_pkg;

  localparam logic [5:0] PREAMBLE_RESET = 6'd32;
  localparam logic [7:0] FRAME_BITS     = 8'd32;
  localparam logic [7:0] FLUSH_SLOTS    = 8'd32;
  localparam logic [7:0] TA_SLOT        = 8'd14;
  localparam logic [7:0] LAST_DATA_SLOT = 8'd30;
  localparam logic [15:0] ERROR_DATA    = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_C22_WRITE = 2'd0,
    OP_C22_READ  = 2'd1,
    OP_C45_WRITE = 2'd2,
    OP_C45_READ  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ADDR  = 2'd1,
    PH_MAIN  = 2'd2,
    PH_FLUSH = 2'd3
  } phase_e;

  typedef enum logic {
    ITEM_START = 1'b0,
    ITEM_SLOT  = 1'b1
  } item_kind_e;

  typedef struct packed {
    item_kind_e  kind;
    op_e         op;
    logic [4:0]  phy;
    logic [4:0]  dev;
    logic [15:0] regad;
    logic [15:0] wdata;
    logic        mdi;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  // 32 bits that follow the preamble, msb first
  function automatic logic [31:0] frame_word(
    input logic        addr_frame,
    input op_e         op,
    input logic [4:0]  phy,
    input logic [4:0]  dev,
    input logic [15:0] regad,
    input logic [15:0] wdata
  );
    logic        st2;
    logic [1:0]  opc;
    logic [4:0]  field;
    logic [15:0] data;
    unique case (op)
      OP_C22_WRITE: opc = 2'b01;
      OP_C22_READ:  opc = 2'b10;
      OP_C45_WRITE: opc = 2'b01;
      OP_C45_READ:  opc = 2'b11;
      default:      opc = 2'b01;
    endcase
    if (addr_frame) begin
      st2   = 1'b0;
      opc   = 2'b00;
      field = dev;
      data  = regad;
    end else begin
      st2   = ~op[1];
      field = op[1] ? dev : regad[4:0];
      data  = wdata;
    end
    frame_word = {1'b0, st2, opc, phy, field, 2'b10, data};
  endfunction

endpackage

// ----- rtl/mmm_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mdio management master channels
// request and result channels with valid/ready handshake
// ---------------------------------------------------------------------------
interface mmm_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [1:0]  operation;
  logic [4:0]  phy_address;
  logic [4:0]  device_address;
  logic [15:0] reg_address;
  logic [15:0] write_data;
  logic        mdio_in;

  modport source (
    output valid, func, operation, phy_address, device_address, reg_address,
           write_data, mdio_in,
    input  ready
  );
  modport sink (
    input  valid, func, operation, phy_address, device_address, reg_address,
           write_data, mdio_in,
    output ready
  );
endinterface

interface mmm_out_if;
  logic        valid;
  logic        ready;
  logic        mdio_out;
  logic        busy_res;
  logic        done_res;
  logic [15:0] read_data;
  logic        read_error;

  modport source (
    output valid, mdio_out, busy_res, done_res, read_data, read_error,
    input  ready
  );
  modport sink (
    input  valid, mdio_out, busy_res, done_res, read_data, read_error,
    output ready
  );
endinterface

// ----- rtl/mdio_management_master.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mdio management master
// clause 22 / clause 45 mdio frame serializer, one result per request
//
// in_i carries requests: a start request latches an operation and target,
// a slot request advances the frame by one mdc period and brings the
// sampled mdio level. out_o returns one result per request: the mdio level
// to drive (1 is released), busy, done, read data and read error.
// cfg_we_i / cfg_wdata_i write the preamble length, taken at the clock edge.
// A request enters a two-entry queue and its result is registered; the
// block takes one request per cycle while out_o takes each result.
// When out_o stalls the result holds, the queue fills and in_i.ready drops
// after two more requests; nothing is lost.
// Reset empties the queue and the output register, returns the sequencer
// to idle and sets the preamble length to 32.
// ---------------------------------------------------------------------------
module mdio_management_master (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [5:0] cfg_wdata_i,
  mmm_in_if.sink     in_i,
  mmm_out_if.source  out_o
);
  import mmm_pkg::*;

  logic [5:0]  preamble_q, preamble_d;
  queue_head_t head;
  logic        pop;

  assign preamble_d = cfg_we_i ? cfg_wdata_i : preamble_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preamble_q <= PREAMBLE_RESET;
    end else begin
      preamble_q <= preamble_d;
    end
  end

  mmm_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .head_o (head),
    .pop_i  (pop)
  );

  mmm_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .preamble_i (preamble_q),
    .head_i     (head),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule

// ----- rtl/mmm_front.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mdio management master front end
// accepts requests, classifies them and holds them in a two-entry queue
// ---------------------------------------------------------------------------
module mmm_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  mmm_in_if.sink              in_i,
  output mmm_pkg::queue_head_t head_o,
  input  logic                pop_i
);
  import mmm_pkg::*;

  item_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  logic       pop;
  item_t      item_in;

  always_comb begin
    item_in.kind  = in_i.func ? ITEM_SLOT : ITEM_START;
    item_in.op    = op_e'(in_i.operation);
    item_in.phy   = in_i.phy_address;
    item_in.dev   = in_i.device_address;
    item_in.regad = in_i.reg_address;
    item_in.wdata = in_i.write_data;
    item_in.mdi   = in_i.mdio_in;
  end

  assign in_i.ready = (cnt_q != 2'd2);
  assign push       = in_i.valid && in_i.ready;
  assign pop        = pop_i && (cnt_q != 2'd0);

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.item  = mem_q[rd_ptr_q];

endmodule

// ----- rtl/mmm_back.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mdio management master frame engine
// runs the frame sequencer one request per cycle, while out_o takes each result, into an output register
// ---------------------------------------------------------------------------
module mmm_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [5:0]           preamble_i,
  input  mmm_pkg::queue_head_t head_i,
  output logic                 pop_o,
  mmm_out_if.source            out_o
);
  import mmm_pkg::*;

  phase_e      phase_q, phase_d;
  logic [7:0]  slot_q, slot_d;
  op_e         op_q, op_d;
  logic [4:0]  phy_q, phy_d;
  logic [4:0]  dev_q, dev_d;
  logic [15:0] reg_q, reg_d;
  logic [15:0] wval_q, wval_d;
  logic [15:0] acc_q, acc_d;

  logic        out_valid_q, out_valid_d;
  logic        mdo_q, busy_q, done_q, rerr_q;
  logic [15:0] rdata_q;

  logic        mdo, done, rerr;
  logic [15:0] rdata;

  logic        advance;
  item_t       it;
  logic        is_slot;
  logic        addr_fr;
  logic        is_read;
  logic        p_ge;
  logic [7:0]  k;
  logic [7:0]  slot_inc;
  logic [31:0] word;
  logic        word_bit;

  assign it      = head_i.item;
  assign advance = head_i.valid && (!out_valid_q || out_o.ready);
  assign pop_o   = advance;
  assign is_slot = (it.kind == ITEM_SLOT);

  assign addr_fr  = (phase_q == PH_ADDR);
  assign is_read  = (phase_q == PH_MAIN) && op_q[0];
  assign p_ge     = slot_q >= {2'b00, preamble_i};
  assign k        = slot_q - {2'b00, preamble_i};
  assign slot_inc = slot_q + 8'd1;
  assign word     = frame_word(addr_fr, op_q, phy_q, dev_q, reg_q, wval_q);
  assign word_bit = word[~k[4:0]];

  // next state
  always_comb begin
    phase_d = phase_q;
    slot_d  = slot_q;
    op_d    = op_q;
    phy_d   = phy_q;
    dev_d   = dev_q;
    reg_d   = reg_q;
    wval_d  = wval_q;
    acc_d   = acc_q;
    if (advance) begin
      if (!is_slot) begin
        if (phase_q == PH_IDLE) begin
          op_d    = it.op;
          phy_d   = it.phy;
          dev_d   = it.dev;
          reg_d   = it.regad;
          wval_d  = it.wdata;
          acc_d   = 16'd0;
          slot_d  = 8'd0;
          phase_d = it.op[1] ? PH_ADDR : PH_MAIN;
        end
      end else begin
        unique case (phase_q)
          PH_IDLE: begin
          end
          PH_FLUSH: begin
            slot_d = slot_inc;
            if (slot_inc >= FLUSH_SLOTS) begin
              phase_d = PH_IDLE;
              slot_d  = 8'd0;
            end
          end
          PH_ADDR, PH_MAIN: begin
            slot_d = slot_inc;
            if (p_ge) begin
              if (!is_read) begin
                if (k >= FRAME_BITS) begin
                  phase_d = addr_fr ? PH_MAIN : PH_IDLE;
                  slot_d  = 8'd0;
                end
              end else if (k == TA_SLOT) begin
                if (it.mdi) begin
                  phase_d = PH_FLUSH;
                  slot_d  = 8'd0;
                end
              end else if (k > TA_SLOT && k <= LAST_DATA_SLOT) begin
                acc_d = {acc_q[14:0], it.mdi};
              end else if (k > LAST_DATA_SLOT) begin
                phase_d = PH_IDLE;
                slot_d  = 8'd0;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // result of the current request
  always_comb begin
    mdo   = 1'b1;
    done  = 1'b0;
    rdata = 16'd0;
    rerr  = 1'b0;
    if (is_slot) begin
      unique case (phase_q)
        PH_IDLE: begin
        end
        PH_FLUSH: begin
          if (slot_inc >= FLUSH_SLOTS) begin
            done  = 1'b1;
            rdata = ERROR_DATA;
            rerr  = 1'b1;
          end
        end
        PH_ADDR, PH_MAIN: begin
          if (p_ge) begin
            if (!is_read) begin
              if (k < FRAME_BITS) begin
                mdo = word_bit;
              end else if (!addr_fr) begin
                done = 1'b1;
              end
            end else if (k < TA_SLOT) begin
              mdo = word_bit;
            end else if (k > LAST_DATA_SLOT) begin
              done  = 1'b1;
              rdata = acc_q;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      slot_q      <= 8'd0;
      op_q        <= OP_C22_WRITE;
      phy_q       <= 5'd0;
      dev_q       <= 5'd0;
      reg_q       <= 16'd0;
      wval_q      <= 16'd0;
      acc_q       <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      slot_q      <= slot_d;
      op_q        <= op_d;
      phy_q       <= phy_d;
      dev_q       <= dev_d;
      reg_q       <= reg_d;
      wval_q      <= wval_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      mdo_q   <= mdo;
      busy_q  <= (phase_d != PH_IDLE);
      done_q  <= done;
      rdata_q <= rdata;
      rerr_q  <= rerr;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.mdio_out   = mdo_q;
  assign out_o.busy_res   = busy_q;
  assign out_o.done_res   = done_q;
  assign out_o.read_data  = rdata_q;
  assign out_o.read_error = rerr_q;

endmodule

// ----- bench/tb_mdio_management_master.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mdio management master testbench
// drives start and bit-slot requests through the valid/ready channels,
// predicts every result with a cycle-free frame model held in a scoreboard
// class and compares each result field by field, across several preamble
// lengths and idle/stall patterns, including a long result hold-off
// ---------------------------------------------------------------------------
module tb_mdio_management_master;
  import mmm_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int NUM_PHASES = 9;
  localparam int PRESSURE_PHASE = 4;
  localparam int ITEMS_PER_PHASE = 115;
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    logic        mdo;
    logic        busy;
    logic        done;
    logic [15:0] rdata;
    logic        rerr;
  } slot_result_t;

  class mdio_slot_checker;
    logic [5:0]   preamble_len;
    logic [7:0]   slot_pos;
    phase_e       phase;
    op_e          op;
    logic [4:0]   phy;
    logic [4:0]   dev;
    logic [15:0]  regad;
    logic [15:0]  wdata;
    logic [15:0]  read_shift;
    slot_result_t pending_slots[$];
    int           failures;

    function new();
      preamble_len = PREAMBLE_RESET;
      slot_pos     = '0;
      phase        = PH_IDLE;
      op           = OP_C22_WRITE;
      phy          = '0;
      dev          = '0;
      regad        = '0;
      wdata        = '0;
      read_shift   = '0;
      failures     = 0;
    endfunction

    function void set_preamble(logic [5:0] value);
      preamble_len = value;
    endfunction

    function bit is_idle();
      return phase == PH_IDLE;
    endfunction

    function bit is_c45();
      return op == OP_C45_WRITE || op == OP_C45_READ;
    endfunction

    function bit is_read();
      return op == OP_C22_READ || op == OP_C45_READ;
    endfunction

    // next slot samples the turnaround bit of a read frame
    function bit at_turnaround();
      if (phase != PH_MAIN || !is_read() || slot_pos < {2'b00, preamble_len}) return 1'b0;
      return (slot_pos - {2'b00, preamble_len}) == TA_SLOT;
    endfunction

    function logic [31:0] frame_bits(bit addr_frame);
      logic [1:0] opc;
      logic [4:0] field;
      case (op)
        OP_C22_READ: opc = 2'b10;
        OP_C45_READ: opc = 2'b11;
        default:     opc = 2'b01;
      endcase
      field = is_c45() ? dev : regad[4:0];
      if (addr_frame) return {4'b0000, phy, dev, 2'b10, regad};
      return {1'b0, ~is_c45(), opc, phy, field, 2'b10, wdata};
    endfunction

    // advances the frame by one request, returns 1 if the block acts on it
    function bit advance_frame(item_t it, output slot_result_t res);
      bit          addr_frame;
      bit          rd;
      bit          acted;
      int          k;
      logic [7:0]  nxt;
      logic [31:0] w;
      res   = '{mdo: 1'b1, busy: 1'b0, done: 1'b0, rdata: 16'h0000, rerr: 1'b0};
      acted = 1'b1;
      if (it.kind == ITEM_START) begin
        if (phase == PH_IDLE) begin
          op         = it.op;
          phy        = it.phy;
          dev        = it.dev;
          regad      = it.regad;
          wdata      = it.wdata;
          read_shift = '0;
          slot_pos   = '0;
          phase      = is_c45() ? PH_ADDR : PH_MAIN;
        end else begin
          acted = 1'b0;
        end
      end else if (phase == PH_FLUSH) begin
        slot_pos = slot_pos + 8'd1;
        if (slot_pos >= FLUSH_SLOTS) begin
          res.done  = 1'b1;
          res.rdata = ERROR_DATA;
          res.rerr  = 1'b1;
          phase     = PH_IDLE;
          slot_pos  = '0;
        end
      end else if (phase != PH_IDLE) begin
        addr_frame = phase == PH_ADDR;
        rd         = !addr_frame && is_read();
        nxt        = slot_pos + 8'd1;
        if (slot_pos >= {2'b00, preamble_len}) begin
          k = int'(slot_pos) - int'(preamble_len);
          w = frame_bits(addr_frame);
          if (!rd) begin
            if (k < int'(FRAME_BITS)) begin
              res.mdo = w[31-k];
            end else if (addr_frame) begin
              phase = PH_MAIN;
              nxt   = '0;
            end else begin
              res.done = 1'b1;
              phase    = PH_IDLE;
              nxt      = '0;
            end
          end else if (k < int'(TA_SLOT)) begin
            res.mdo = w[31-k];
          end else if (k == int'(TA_SLOT)) begin
            if (it.mdi) begin
              phase    = PH_FLUSH;
              nxt      = '0;
            end
          end else if (k <= int'(LAST_DATA_SLOT)) begin
            read_shift = {read_shift[14:0], it.mdi};
          end else begin
            res.done  = 1'b1;
            res.rdata = read_shift;
            phase     = PH_IDLE;
            nxt       = '0;
          end
        end
        slot_pos = nxt;
      end else begin
        acted = 1'b0;
      end
      res.busy = phase != PH_IDLE;
      return acted;
    endfunction

    function bit note_request(item_t it);
      slot_result_t res;
      bit           acted;
      acted = advance_frame(it, res);
      pending_slots.push_back(res);
      return acted;
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        failures++;
      end
    endfunction

    function void check_result(slot_result_t got);
      slot_result_t want;
      if (pending_slots.size() == 0) begin
        $display("%0t: result with no request pending, actual %0h", $time, got);
        failures++;
        return;
      end
      want = pending_slots.pop_front();
      compare_field("mdio_out", 16'(want.mdo), 16'(got.mdo));
      compare_field("busy_res", 16'(want.busy), 16'(got.busy));
      compare_field("done_res", 16'(want.done), 16'(got.done));
      compare_field("read_data", want.rdata, got.rdata);
      compare_field("read_error", 16'(want.rerr), 16'(got.rerr));
    endfunction

    function int outstanding();
      return pending_slots.size();
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [5:0] cfg_wdata_i;

  mmm_in_if  in_if();
  mmm_out_if out_if();

  mdio_management_master uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  mdio_slot_checker sb;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_req;
  int hold_left;
  int quiet_cycles;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // result side: check, then pick ready for the next cycle
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        sb.check_result('{mdo: out_if.mdio_out, busy: out_if.busy_res,
                          done: out_if.done_res, rdata: out_if.read_data,
                          rerr: out_if.read_error});
      end
      if (hold_off_req > 0) begin
        hold_left    = hold_off_req;
        hold_off_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic send_request(input item_t it, output bit acted);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.func           <= it.kind;
    in_if.operation      <= it.op;
    in_if.phy_address    <= it.phy;
    in_if.device_address <= it.dev;
    in_if.reg_address    <= it.regad;
    in_if.write_data     <= it.wdata;
    in_if.mdio_in        <= it.mdi;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    acted = sb.note_request(it);
  endtask

  task automatic wait_for_drain();
    in_if.valid <= 1'b0;
    while (sb.outstanding() > 0) @(posedge clk_i);
  endtask

  task automatic write_preamble(input logic [5:0] value);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    sb.set_preamble(value);
    cfg_we_i <= 1'b0;
  endtask

  task automatic directed_requests();
    item_t list[4];
    bit    acted;
    // slots while idle, then a clause 45 read with every field at its top,
    // then a start while busy that must be ignored
    list[0] = '{ITEM_SLOT, OP_C22_WRITE, 5'd0, 5'd0, 16'h0000, 16'h0000, 1'b1};
    list[1] = '{ITEM_SLOT, OP_C45_READ, 5'd31, 5'd31, 16'hFFFF, 16'hFFFF, 1'b0};
    list[2] = '{ITEM_START, OP_C45_READ, 5'd31, 5'd31, 16'hFFFF, 16'hFFFF, 1'b1};
    list[3] = '{ITEM_START, OP_C22_WRITE, 5'd0, 5'd0, 16'h0000, 16'h0000, 1'b0};
    foreach (list[i]) send_request(list[i], acted);
  endtask

  // mostly well-formed request sequences with random content, some noise
  task automatic random_requests(input int count);
    item_t it;
    bit    acted;
    int    n;
    n = 0;
    while (n < count) begin
      it.op    = op_e'($urandom_range(3));
      it.phy   = 5'($urandom_range(31));
      it.dev   = 5'($urandom_range(31));
      it.regad = 16'($urandom_range(16'hFFFF));
      it.wdata = 16'($urandom_range(16'hFFFF));
      it.mdi   = 1'($urandom_range(1));
      if (sb.is_idle()) begin
        it.kind = ($urandom_range(99) < 92) ? ITEM_START : ITEM_SLOT;
      end else begin
        it.kind = ($urandom_range(99) < 4) ? ITEM_START : ITEM_SLOT;
      end
      if (sb.at_turnaround()) it.mdi = ($urandom_range(99) < 15);
      send_request(it, acted);
      if (acted) n++;
    end
  endtask

  initial begin
    logic [5:0] preamble_plan[NUM_PHASES];
    sb                   = new();
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_wdata_i          = '0;
    in_if.valid          = 1'b0;
    in_if.func           = ITEM_SLOT;
    in_if.operation      = OP_C22_WRITE;
    in_if.phy_address    = '0;
    in_if.device_address = '0;
    in_if.reg_address    = '0;
    in_if.write_data     = '0;
    in_if.mdio_in        = 1'b1;
    send_idle_pct        = 0;
    recv_stall_pct       = 0;
    hold_off_req         = 0;
    hold_left            = 0;
    quiet_cycles         = 0;
    preamble_plan = '{PREAMBLE_RESET, 6'd1, 6'd0, 6'd63, 6'd4, 6'd2,
                      6'($urandom_range(6)), 6'($urandom_range(32, 1)), 6'd32};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        wait_for_drain();
        repeat (4) @(posedge clk_i);
        write_preamble(preamble_plan[p]);
      end
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      if (p == 0) directed_requests();
      // results held back while requests keep coming
      if (p == PRESSURE_PHASE) hold_off_req = HOLD_OFF_CYCLES;
      random_requests(ITEMS_PER_PHASE);
    end

    recv_stall_pct = 0;
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.outstanding() > 0) begin
      $display("%0t: %0d results never arrived", $time, sb.outstanding());
      sb.failures++;
    end
    if (sb.failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
